// ===== hw/rtl/pcg_pkg.sv =====
// Shared types, constants and the compass kernel function for the Prewitt compass gradient.
package pcg_pkg;

   localparam int PIXEL_W      = 8;
   localparam int GRAD_W       = 10;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int WIN_SIZE     = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0]  CFG_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] CFG_HEIGHT_RESET = 13'd480;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type window_type [0:WIN_SIZE-1];

   // absolute difference of two three-pixel sums
   function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] p,
                                                  input logic [GRAD_W-1:0] q);
      logic signed [GRAD_W:0] d;
      logic signed [GRAD_W:0] m;
      d = $signed({1'b0, p}) - $signed({1'b0, q});
      m = d[GRAD_W] ? -d : d;
      return m[GRAD_W-1:0];
   endfunction

   function automatic logic [GRAD_W-1:0] sum3(input pixel_type x, input pixel_type y,
                                              input pixel_type z);
      return GRAD_W'(x) + GRAD_W'(y) + GRAD_W'(z);
   endfunction

   // window is row-major, index 0 top left; the centre does not take part
   function automatic logic [GRAD_W-1:0] compass_max(input window_type w);
      logic [GRAD_W-1:0] hz;
      logic [GRAD_W-1:0] vt;
      logic [GRAD_W-1:0] d1;
      logic [GRAD_W-1:0] d2;
      logic [GRAD_W-1:0] m01;
      logic [GRAD_W-1:0] m23;
      hz  = abs_diff(sum3(w[0], w[1], w[2]), sum3(w[6], w[7], w[8]));
      vt  = abs_diff(sum3(w[0], w[3], w[6]), sum3(w[2], w[5], w[8]));
      d1  = abs_diff(sum3(w[0], w[1], w[3]), sum3(w[5], w[7], w[8]));
      d2  = abs_diff(sum3(w[3], w[6], w[7]), sum3(w[1], w[2], w[5]));
      m01 = (vt > hz) ? vt : hz;
      m23 = (d2 > d1) ? d2 : d1;
      return (m23 > m01) ? m23 : m01;
   endfunction

endpackage

// ===== hw/rtl/prewitt_compass_gradient.sv =====
// Streaming 3x3 Prewitt compass gradient with two line stores and a sliding window.
//
// Usage: grey pixels enter in raster order on the req_ channel (req_mode = 0),
// one transfer per clock when both sides keep up. Each pixel transfer from the
// second row on (after the first column of that row) yields one result on the
// rsp_ channel: the compass maximum for the pixel one row and one column back,
// 0 on the image border. The result for a pixel is registered in the cycle
// after the transfer of the pixel one row plus one column later. Throughput is
// one item per cycle while the receiver keeps up, set by one read and one
// write per cycle on each line store, whose read is registered ahead at the
// column of the next pixel. After the last pixel of a frame,
// drain items (req_mode = 1) each flush one pending border result; the final
// result of the frame carries rsp_last. The csr_ port sets width and height;
// any write restarts the frame and must occur while the block is idle.
// Reset clears counters and the result valid flag and sets 640 x 480; line
// stores are not cleared. When the receiver stalls, the result register holds
// and req_ready drops until the result is taken.
module prewitt_compass_gradient #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [pcg_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pcg_pkg::GRAD_W-1:0]       rsp_gradient,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [pcg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pcg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pcg_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int W_CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int H_CNT_W = $clog2(MAX_HEIGHT + 1);
   localparam int TOT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   logic [CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff;
   logic [31:0]             w_raw;
   logic [31:0]             h_raw;
   logic [31:0]             eff_w32;
   logic [31:0]             eff_h32;
   logic [W_CNT_W-1:0]      eff_w;
   logic [H_CNT_W-1:0]      eff_h;
   logic [TOT_W-1:0]        total_ff;

   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [TOT_W-1:0]        emitted_ff, emitted_in;
   logic [W_CNT_W-1:0]      col_inc;
   logic [H_CNT_W-1:0]      row_inc;

   pixel_type               upper_mem [0:MAX_WIDTH-1];
   pixel_type               lower_mem [0:MAX_WIDTH-1];
   pixel_type               rd_up_ff;
   pixel_type               rd_lo_ff;
   window_type              win_ff, win_in;

   logic                    req_acc, pix_acc, drn_acc;
   logic                    draining;
   logic                    emit;
   logic                    interior;
   logic [TOT_W-1:0]        emitted_inc;
   logic                    frame_done;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GRAD_W-1:0]       rsp_gradient_ff, rsp_gradient_in;
   logic                    rsp_last_ff, rsp_last_in;

   // clamp the configured sizes into the supported range
   always_comb begin
      w_raw = 32'(cfg_width_ff);
      h_raw = 32'(cfg_height_ff);
      priority if (w_raw < 32'd3) eff_w32 = 32'd3;
      else if (w_raw > 32'(MAX_WIDTH)) eff_w32 = 32'(MAX_WIDTH);
      else eff_w32 = w_raw;
      priority if (h_raw < 32'd3) eff_h32 = 32'd3;
      else if (h_raw > 32'(MAX_HEIGHT)) eff_h32 = 32'(MAX_HEIGHT);
      else eff_h32 = h_raw;
   end

   assign eff_w = eff_w32[W_CNT_W-1:0];
   assign eff_h = eff_h32[H_CNT_W-1:0];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;
   assign pix_acc   = req_acc && (req_mode == MODE_PIXEL);
   assign drn_acc   = req_acc && (req_mode == MODE_DRAIN);

   assign draining    = (row_ff == '0) && (col_ff == '0) && (emitted_ff != '0);
   assign emitted_inc = emitted_ff + TOT_W'(1);
   assign frame_done  = emitted_inc >= total_ff;

   assign col_inc  = W_CNT_W'(col_ff) + W_CNT_W'(1);
   assign row_inc  = H_CNT_W'(row_ff) + H_CNT_W'(1);
   assign emit     = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));
   assign interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   // slide the window one column: new right column from the stores and the pixel
   always_comb begin
      win_in = win_ff;
      if (pix_acc) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = rd_up_ff;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = rd_lo_ff;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = req_pixel;
      end
   end

   // raster position and frame bookkeeping
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      emitted_in = emitted_ff;
      if (csr_we) begin
         col_in     = '0;
         row_in     = '0;
         emitted_in = '0;
      end else if (pix_acc) begin
         if (col_inc >= eff_w) begin
            col_in = '0;
            if (row_inc >= eff_h) begin
               row_in = '0;
            end else begin
               row_in = row_inc[ROW_W-1:0];
            end
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
         // a pixel arriving while a finished frame drains drops what is pending
         if (draining) begin
            emitted_in = '0;
         end else if (emit) begin
            emitted_in = emitted_inc;
         end
      end else if (drn_acc && draining) begin
         emitted_in = frame_done ? '0 : emitted_inc;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_gradient_in = rsp_gradient_ff;
      rsp_last_in     = rsp_last_ff;
      if (pix_acc) begin
         rsp_valid_in    = emit;
         rsp_gradient_in = interior ? compass_max(win_in) : '0;
         rsp_last_in     = 1'b0;
      end else if (drn_acc) begin
         rsp_valid_in    = draining;
         rsp_gradient_in = '0;
         rsp_last_in     = frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CFG_WIDTH_RESET;
         cfg_height_ff <= CFG_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
               default:          cfg_width_ff  <= cfg_width_ff;
            endcase
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff        <= TOT_W'(eff_w) * TOT_W'(eff_h);
      win_ff          <= win_in;
      rsp_gradient_ff <= rsp_gradient_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // line stores: write the current column, prefetch the column of the next pixel
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         upper_mem[col_ff] <= rd_lo_ff;
         lower_mem[col_ff] <= req_pixel;
      end
      rd_up_ff <= upper_mem[col_in];
      rd_lo_ff <= lower_mem[col_in];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gradient = rsp_gradient_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
